/* hdl/assert_macros.svh */
// assertion macros for the checker file
// each macro expects clk and rst_n in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PEG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PEG_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/peg_pkg.sv */
// shared field widths, reset value and result type of the edge placer
// no dependencies
package peg_pkg;

    localparam int COLUMN_W        = 12;
    localparam int EDGE_NUMBER_W   = 2;
    localparam int TIE_RANDOM_W    = 16;
    localparam int CHECK_INDEX_W   = 9;
    localparam int TIE_COUNT_W     = 10;
    localparam int SEARCH_LEVELS_W = 9;
    localparam int ACTIVE_W        = 10;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 10'd368;
    localparam int LEVELS_MAX = 511;

    typedef struct packed {
        logic [CHECK_INDEX_W-1:0]   check_index;
        logic [TIE_COUNT_W-1:0]     tie_count;
        logic [SEARCH_LEVELS_W-1:0] search_levels;
        logic                       duplicate_edge;
    } peg_result_t;

endpackage

/* hdl/peg_req_if.sv */
// request channel: one edge to place per item
// depends on peg_pkg
interface peg_req_if;
    import peg_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [COLUMN_W-1:0]      column;
    logic [EDGE_NUMBER_W-1:0] edge_number;
    logic [TIE_RANDOM_W-1:0]  tie_random;

    modport source (output valid, column, edge_number, tie_random, input ready);
    modport sink (input valid, column, edge_number, tie_random, output ready);
endinterface

/* hdl/peg_res_if.sv */
// result channel: chosen check and search statistics per item
// depends on peg_pkg
interface peg_res_if;
    import peg_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CHECK_INDEX_W-1:0]   check_index;
    logic [TIE_COUNT_W-1:0]     tie_count;
    logic [SEARCH_LEVELS_W-1:0] search_levels;
    logic                       duplicate_edge;

    modport source (output valid, check_index, tie_count, search_levels, duplicate_edge,
                    input ready);
    modport sink (input valid, check_index, tie_count, search_levels, duplicate_edge,
                  output ready);
endinterface

/* hdl/peg_cfg_if.sv */
// configuration write channel for the active check count
// depends on peg_pkg
interface peg_cfg_if;
    import peg_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTIVE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

/* hdl/peg_mod.sv */
// restoring remainder unit, one quotient bit per cycle
// standalone, no package use
module peg_mod #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [DEN_W-1:0] rem
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            // remainder stays below den, so the trial fits one extra bit
            if (trial >= {1'b0, den_reg})
                rem_next = DEN_W'(trial - {1'b0, den_reg});
            else
                rem_next = trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;
endmodule

/* hdl/peg_ldpc_edge_placer.sv */
// channel   | role | payload
// request   | sink | column, edge_number, tie_random
// result    | src  | check_index, tie_count, search_levels, duplicate_edge
// cfg       | sink | data (active check count), always ready
//
// one item at a time; edge 0 runs two candidate scans, the remainder unit and a duplicate
// scan over the columns already listed on the chosen check
// later edges add a sweep clearing max(NUM_VARS, NUM_CHECKS) words and, per search level,
// a scan of the NUM_VARS variables reading each frontier edge and of the NUM_CHECKS checks
// reading each listed column; after reset a sweep of NUM_CHECKS entries zeroes the degrees
// a finished item waits in the output register while the next item is taken
// depends on peg_pkg, the three channel interfaces and peg_mod
module peg_ldpc_edge_placer #(
    parameter int NUM_VARS         = 4096,
    parameter int NUM_CHECKS       = 512,
    parameter int VAR_DEGREE       = 3,
    parameter int MAX_CHECK_DEGREE = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    peg_req_if.sink   request,
    peg_res_if.source result,
    peg_cfg_if.sink   cfg
);
    import peg_pkg::*;

    localparam int VW  = $clog2(NUM_VARS);
    localparam int CW  = $clog2(NUM_CHECKS);
    localparam int SW  = $clog2(VAR_DEGREE);
    localparam int MW  = $clog2(MAX_CHECK_DEGREE);
    localparam int DW  = $clog2(MAX_CHECK_DEGREE + 1);
    localparam int EW  = $clog2(VAR_DEGREE + 1);
    localparam int SCW = (DW > EW) ? DW : EW;
    localparam int LW  = $clog2(NUM_CHECKS + 3);
    localparam int NW  = $clog2(NUM_CHECKS + 1);
    localparam int XN  = (NUM_VARS > NUM_CHECKS) ? NUM_VARS : NUM_CHECKS;
    localparam int XW  = $clog2(XN);
    localparam int CC_DEPTH = NUM_VARS << SW;
    localparam int CL_DEPTH = NUM_CHECKS << MW;

    localparam logic [4:0] ST_INIT   = 5'd0;
    localparam logic [4:0] ST_IDLE   = 5'd1;
    localparam logic [4:0] ST_REDUCE = 5'd2;
    localparam logic [4:0] ST_CLR    = 5'd3;
    localparam logic [4:0] ST_A_CHK  = 5'd4;
    localparam logic [4:0] ST_E_RD   = 5'd5;
    localparam logic [4:0] ST_E_CHK  = 5'd6;
    localparam logic [4:0] ST_E_UPD  = 5'd7;
    localparam logic [4:0] ST_B_GO   = 5'd8;
    localparam logic [4:0] ST_B_SCAN = 5'd9;
    localparam logic [4:0] ST_B_RD   = 5'd10;
    localparam logic [4:0] ST_B_WR   = 5'd11;
    localparam logic [4:0] ST_DECIDE = 5'd12;
    localparam logic [4:0] ST_P_GO   = 5'd13;
    localparam logic [4:0] ST_P1     = 5'd14;
    localparam logic [4:0] ST_MOD_GO = 5'd15;
    localparam logic [4:0] ST_MOD_WT = 5'd16;
    localparam logic [4:0] ST_P2     = 5'd17;
    localparam logic [4:0] ST_D_GO   = 5'd18;
    localparam logic [4:0] ST_D_DEG  = 5'd19;
    localparam logic [4:0] ST_D_RD   = 5'd20;
    localparam logic [4:0] ST_D_CMP  = 5'd21;
    localparam logic [4:0] ST_WB     = 5'd22;
    localparam logic [4:0] ST_OUT    = 5'd23;

    // memories
    logic [CW-1:0] cc_mem    [CC_DEPTH];
    logic [VW-1:0] cl_mem    [CL_DEPTH];
    logic [DW-1:0] deg_mem   [NUM_CHECKS];
    logic [LW-1:0] reach_mem [NUM_CHECKS];
    logic [LW-1:0] mark_mem  [NUM_VARS];

    logic [VW+SW-1:0] cc_ra, cc_wa;
    logic [CW+MW-1:0] cl_ra, cl_wa;
    logic [CW-1:0]    reach_ra, reach_wa, deg_wa;
    logic [VW-1:0]    mark_wa;
    logic             cc_we, cl_we, deg_we, reach_we, mark_we;
    logic [CW-1:0]    cc_wd, cc_rd;
    logic [VW-1:0]    cl_wd, cl_rd;
    logic [DW-1:0]    deg_wd, deg_rd;
    logic [LW-1:0]    reach_wd, reach_rd, mark_wd, mark_rd;

    // control and working registers
    logic [4:0]          state_reg, state_next;
    logic [XW-1:0]       x_reg, x_next;
    logic [VW-1:0]       w_reg, w_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [SCW-1:0]      s_reg, s_next;
    logic [SCW-1:0]      n_reg, n_next;
    logic [LW-1:0]       level_reg, level_next;
    logic                newc_reg, newc_next;
    logic                anyn_reg, anyn_next;
    logic                all_reg, all_next;
    logic [NW-1:0]       rcnt_reg, rcnt_next;
    logic [NW-1:0]       a_reg, a_next;
    logic [DW-1:0]       best_reg, best_next;
    logic [NW-1:0]       cnt_reg, cnt_next;
    logic [NW-1:0]       pos_reg, pos_next;
    logic [CW-1:0]       chosen_reg, chosen_next;
    logic [CW-1:0]       chk_reg, chk_next;
    logic [DW-1:0]       deg_reg, deg_next;
    logic                dup_reg, dup_next;
    logic                e0_reg, e0_next;
    logic [SW-1:0]       e_reg, e_next;
    logic [COLUMN_W-1:0] col_reg, col_next;
    logic [TIE_RANDOM_W-1:0] sel_reg, sel_next;
    logic [ACTIVE_W-1:0] active_reg;
    peg_result_t         out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic          mod_start, mod_done;
    logic [NW-1:0] mod_rem;
    logic [VW-1:0] col_v;
    logic [SCW-1:0] n_w;
    logic          cand;
    logic          i_last, i_alast;
    logic [SCW-1:0] s_inc;

    peg_mod #(
        .NUM_W (TIE_RANDOM_W),
        .DEN_W (NW)
    ) u_peg_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .num   (sel_reg),
        .den   (cnt_reg),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    assign col_v   = VW'(col_reg);
    assign s_inc   = SCW'(s_reg + 1'b1);
    assign i_last  = (32'(i_reg) == NUM_CHECKS - 1);
    assign i_alast = (NW'(i_reg) == NW'(a_reg - 1'b1));
    assign cand    = e0_reg || (reach_rd == '0) || (all_reg && (reach_rd == level_reg));

    always_comb
    begin
        if (w_reg < col_v)
            n_w = SCW'(VAR_DEGREE);
        else if (w_reg == col_v)
            n_w = SCW'(e_reg);
        else
            n_w = '0;
    end

    always_comb
    begin
        state_next = state_reg;
        x_next = x_reg;
        w_next = w_reg;
        i_next = i_reg;
        s_next = s_reg;
        n_next = n_reg;
        level_next = level_reg;
        newc_next = newc_reg;
        anyn_next = anyn_reg;
        all_next = all_reg;
        rcnt_next = rcnt_reg;
        a_next = a_reg;
        best_next = best_reg;
        cnt_next = cnt_reg;
        pos_next = pos_reg;
        chosen_next = chosen_reg;
        chk_next = chk_reg;
        deg_next = deg_reg;
        dup_next = dup_reg;
        e0_next = e0_reg;
        e_next = e_reg;
        col_next = col_reg;
        sel_next = sel_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg;
        mod_start = 1'b0;
        cc_ra = {w_reg, s_reg[SW-1:0]};
        cl_ra = {i_reg, s_reg[MW-1:0]};
        reach_ra = i_next;
        cc_we = 1'b0;
        cc_wa = {col_v, e_reg};
        cc_wd = chosen_reg;
        cl_we = 1'b0;
        cl_wa = {chosen_reg, deg_reg[MW-1:0]};
        cl_wd = col_v;
        deg_we = 1'b0;
        deg_wa = chosen_reg;
        deg_wd = DW'(deg_reg + 1'b1);
        reach_we = 1'b0;
        reach_wa = x_reg[CW-1:0];
        reach_wd = '0;
        mark_we = 1'b0;
        mark_wa = x_reg[VW-1:0];
        mark_wd = (32'(x_reg) == 32'(col_v)) ? LW'(1) : '0;

        if (out_valid_reg && result.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_INIT:
            begin
                deg_we = 1'b1;
                deg_wa = x_reg[CW-1:0];
                deg_wd = '0;
                x_next = x_reg + 1'b1;
                if (32'(x_reg) == NUM_CHECKS - 1)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    col_next = request.column;
                    if (32'(request.edge_number) >= VAR_DEGREE)
                        e_next = SW'(VAR_DEGREE - 1);
                    else
                        e_next = SW'(request.edge_number);
                    e0_next = (request.edge_number == '0);
                    sel_next = (request.edge_number == '0) ? '0 : request.tie_random;
                    if (active_reg == '0)
                        a_next = NW'(1);
                    else if (32'(active_reg) > NUM_CHECKS)
                        a_next = NW'(NUM_CHECKS);
                    else
                        a_next = NW'(active_reg);
                    level_next = '0;
                    all_next = 1'b0;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                // column modulo NUM_VARS by repeated subtraction
                if (32'(col_reg) >= NUM_VARS)
                    col_next = col_reg - COLUMN_W'(NUM_VARS);
                else if (e0_reg)
                    state_next = ST_P_GO;
                else
                begin
                    x_next = '0;
                    state_next = ST_CLR;
                end
            end
            ST_CLR:
            begin
                // per-search clear; the start column gets mark level 1
                mark_we = (32'(x_reg) < NUM_VARS);
                reach_we = (32'(x_reg) < NUM_CHECKS);
                x_next = x_reg + 1'b1;
                if (32'(x_reg) == XN - 1)
                begin
                    level_next = LW'(1);
                    newc_next = 1'b0;
                    anyn_next = 1'b0;
                    rcnt_next = '0;
                    w_next = '0;
                    state_next = ST_A_CHK;
                end
            end
            ST_A_CHK:
            begin
                if (mark_rd == level_reg && n_w != '0)
                begin
                    n_next = n_w;
                    s_next = '0;
                    state_next = ST_E_RD;
                end
                else if (32'(w_reg) == NUM_VARS - 1)
                    state_next = ST_B_GO;
                else
                    w_next = w_reg + 1'b1;
            end
            ST_E_RD:
            begin
                state_next = ST_E_CHK;
            end
            ST_E_CHK:
            begin
                chk_next = cc_rd;
                reach_ra = cc_rd;
                state_next = ST_E_UPD;
            end
            ST_E_UPD:
            begin
                reach_wa = chk_reg;
                reach_wd = level_reg;
                if (32'(chk_reg) < NUM_CHECKS && reach_rd == '0)
                begin
                    reach_we = 1'b1;
                    newc_next = 1'b1;
                end
                if (s_inc == n_reg)
                begin
                    if (32'(w_reg) == NUM_VARS - 1)
                        state_next = ST_B_GO;
                    else
                    begin
                        w_next = w_reg + 1'b1;
                        state_next = ST_A_CHK;
                    end
                end
                else
                begin
                    s_next = s_inc;
                    state_next = ST_E_RD;
                end
            end
            ST_B_GO:
            begin
                i_next = '0;
                reach_ra = '0;
                rcnt_next = '0;
                state_next = ST_B_SCAN;
            end
            ST_B_SCAN:
            begin
                if (NW'(i_reg) < a_reg && reach_rd != '0)
                    rcnt_next = rcnt_reg + 1'b1;
                if (reach_rd == level_reg && deg_rd != '0)
                begin
                    n_next = SCW'(deg_rd);
                    s_next = '0;
                    state_next = ST_B_RD;
                end
                else if (i_last)
                    state_next = ST_DECIDE;
                else
                begin
                    i_next = i_reg + 1'b1;
                    reach_ra = i_next;
                end
            end
            ST_B_RD:
            begin
                state_next = ST_B_WR;
            end
            ST_B_WR:
            begin
                mark_wa = cl_rd;
                mark_wd = LW'(level_reg + 1'b1);
                if (32'(cl_rd) < NUM_VARS)
                begin
                    mark_we = 1'b1;
                    anyn_next = 1'b1;
                end
                if (s_inc == n_reg)
                begin
                    if (i_last)
                        state_next = ST_DECIDE;
                    else
                    begin
                        i_next = i_reg + 1'b1;
                        reach_ra = i_next;
                        state_next = ST_B_SCAN;
                    end
                end
                else
                begin
                    s_next = s_inc;
                    state_next = ST_B_RD;
                end
            end
            ST_DECIDE:
            begin
                if (rcnt_reg == a_reg)
                begin
                    all_next = 1'b1;
                    state_next = ST_P_GO;
                end
                else if (!newc_reg || !anyn_reg)
                begin
                    all_next = 1'b0;
                    state_next = ST_P_GO;
                end
                else
                begin
                    level_next = level_reg + 1'b1;
                    newc_next = 1'b0;
                    anyn_next = 1'b0;
                    w_next = '0;
                    state_next = ST_A_CHK;
                end
            end
            ST_P_GO:
            begin
                i_next = '0;
                reach_ra = '0;
                cnt_next = '0;
                best_next = '0;
                state_next = ST_P1;
            end
            ST_P1:
            begin
                // least degree among candidates and how many share it
                if (cand)
                begin
                    if (cnt_reg == '0 || deg_rd < best_reg)
                    begin
                        best_next = deg_rd;
                        cnt_next = NW'(1);
                    end
                    else if (deg_rd == best_reg)
                        cnt_next = cnt_reg + 1'b1;
                end
                if (i_alast)
                    state_next = ST_MOD_GO;
                else
                begin
                    i_next = i_reg + 1'b1;
                    reach_ra = i_next;
                end
            end
            ST_MOD_GO:
            begin
                if (cnt_reg == '0)
                begin
                    chosen_next = '0;
                    state_next = ST_D_GO;
                end
                else
                begin
                    mod_start = 1'b1;
                    state_next = ST_MOD_WT;
                end
            end
            ST_MOD_WT:
            begin
                i_next = '0;
                reach_ra = '0;
                pos_next = '0;
                if (mod_done)
                    state_next = ST_P2;
            end
            ST_P2:
            begin
                if (cand && deg_rd == best_reg)
                    pos_next = pos_reg + 1'b1;
                if (cand && deg_rd == best_reg && pos_reg == mod_rem)
                begin
                    chosen_next = i_reg;
                    state_next = ST_D_GO;
                end
                else if (i_alast)
                begin
                    chosen_next = '0;
                    state_next = ST_D_GO;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    reach_ra = i_next;
                end
            end
            ST_D_GO:
            begin
                i_next = chosen_reg;
                reach_ra = chosen_reg;
                state_next = ST_D_DEG;
            end
            ST_D_DEG:
            begin
                deg_next = deg_rd;
                n_next = SCW'(deg_rd);
                s_next = '0;
                dup_next = 1'b0;
                if (deg_rd == '0)
                    state_next = ST_WB;
                else
                    state_next = ST_D_RD;
            end
            ST_D_RD:
            begin
                cl_ra = {chosen_reg, s_reg[MW-1:0]};
                state_next = ST_D_CMP;
            end
            ST_D_CMP:
            begin
                if (cl_rd == col_v)
                    dup_next = 1'b1;
                if (s_inc == n_reg)
                    state_next = ST_WB;
                else
                begin
                    s_next = s_inc;
                    state_next = ST_D_RD;
                end
            end
            ST_WB:
            begin
                cc_we = 1'b1;
                if (32'(deg_reg) < MAX_CHECK_DEGREE)
                begin
                    cl_we = 1'b1;
                    deg_we = 1'b1;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_next.check_index = CHECK_INDEX_W'(chosen_reg);
                    out_next.tie_count = TIE_COUNT_W'(cnt_reg);
                    if (32'(level_reg) > LEVELS_MAX)
                        out_next.search_levels = SEARCH_LEVELS_W'(LEVELS_MAX);
                    else
                        out_next.search_levels = SEARCH_LEVELS_W'(level_reg);
                    out_next.duplicate_edge = dup_reg;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            x_reg <= '0;
            out_valid_reg <= 1'b0;
            active_reg <= ACTIVE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            x_reg <= x_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
                active_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        i_reg <= i_next;
        s_reg <= s_next;
        n_reg <= n_next;
        level_reg <= level_next;
        newc_reg <= newc_next;
        anyn_reg <= anyn_next;
        all_reg <= all_next;
        rcnt_reg <= rcnt_next;
        a_reg <= a_next;
        best_reg <= best_next;
        cnt_reg <= cnt_next;
        pos_reg <= pos_next;
        chosen_reg <= chosen_next;
        chk_reg <= chk_next;
        deg_reg <= deg_next;
        dup_reg <= dup_next;
        e0_reg <= e0_next;
        e_reg <= e_next;
        col_reg <= col_next;
        sel_reg <= sel_next;
        out_reg <= out_next;
    end

    // synchronous memories, registered read
    always_ff @(posedge clk)
    begin
        if (cc_we)
            cc_mem[cc_wa] <= cc_wd;
        cc_rd <= cc_mem[cc_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cl_we)
            cl_mem[cl_wa] <= cl_wd;
        cl_rd <= cl_mem[cl_ra];
    end

    always_ff @(posedge clk)
    begin
        if (deg_we)
            deg_mem[deg_wa] <= deg_wd;
        deg_rd <= deg_mem[i_next];
    end

    always_ff @(posedge clk)
    begin
        if (reach_we)
            reach_mem[reach_wa] <= reach_wd;
        reach_rd <= reach_mem[reach_ra];
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
            mark_mem[mark_wa] <= mark_wd;
        mark_rd <= mark_mem[w_next];
    end

    assign request.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.check_index = out_reg.check_index;
    assign result.tie_count = out_reg.tie_count;
    assign result.search_levels = out_reg.search_levels;
    assign result.duplicate_edge = out_reg.duplicate_edge;
endmodule

/* hdl/peg_checker.sv */
// port-level checks on the edge placer, bound to the top level
// depends on assert_macros.svh and peg_pkg
`include "assert_macros.svh"

module peg_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_valid,
    input logic                            req_ready,
    input logic                            res_valid,
    input logic                            res_ready,
    input logic [peg_pkg::TIE_COUNT_W-1:0] res_tie_count
);
    import peg_pkg::*;

    logic [1:0] pending_reg;
    logic       req_acc, res_acc;

    assign req_acc = req_valid && req_ready;
    assign res_acc = res_valid && res_ready;

    // items taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else if (req_acc && !res_acc)
            pending_reg <= pending_reg + 1'b1;
        else if (res_acc && !req_acc)
            pending_reg <= pending_reg - 1'b1;
    end

    `PEG_ASSERT_IMP(a_no_invented, res_valid, pending_reg != 2'd0, "result without item")
    `PEG_ASSERT_IMP(a_bounded, 1'b1, pending_reg != 2'd3, "too many items in flight")
    `PEG_ASSERT_NXT(a_busy_after, req_acc, !req_ready, "ready right after an item")
    `PEG_ASSERT_NXT(a_hold, res_valid && !res_ready, res_valid && $stable(res_tie_count),
                    "stalled result changed")
endmodule

bind peg_ldpc_edge_placer peg_checker u_peg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (request.valid),
    .req_ready     (request.ready),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .res_tie_count (result.tie_count)
);
